### hdl/flha_pkg.sv
package flha_pkg;

    localparam int HEAP_BYTES_DEF        = 4096;
    localparam int GRANULE_BYTES_DEF     = 8;
    localparam int USED_HEADER_BYTES_DEF = 8;
    localparam int FREE_HEADER_BYTES_DEF = 16;
    localparam int SIZE_ALIGN            = 8;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIT_RD,
        ST_FIT_CHK,
        ST_UNL_RD,
        ST_UNL_CHK,
        ST_UNL_GRD,
        ST_UNL_GCHK,
        ST_SPLIT,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_PRD,
        ST_INS_PCHK,
        ST_INS_LINK,
        ST_INS_PLINK,
        ST_FREE_DONE,
        ST_MRG_PRD,
        ST_MRG_PCHK,
        ST_MRG_NRD,
        ST_MRG_NCHK,
        ST_MRG_N2,
        ST_MRG_N2CHK,
        ST_REPLY
    } state_t;

endpackage

### hdl/free_list_heap_allocator.sv
// A request that needs no list walk goes straight to the reply. An allocate walks the
// free list to find a fit, to unlink it and, if it splits, to insert the remainder; a
// free walks it to insert the block. The walks read one header from memory at a time.
// Throughput: one request at a time; the next is accepted once the result is taken.
// Reset: asynchronous, active low. After reset a clearing pass makes the heap one
// free block at granule 0 and zeroes the other headers; requests wait until it ends.
module free_list_heap_allocator
    import flha_pkg::*;
#(
    parameter int HEAP_BYTES        = HEAP_BYTES_DEF,
    parameter int GRANULE_BYTES     = GRANULE_BYTES_DEF,
    parameter int USED_HEADER_BYTES = USED_HEADER_BYTES_DEF,
    parameter int FREE_HEADER_BYTES = FREE_HEADER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd [0], request_size [13:1], block_address [25:14], zeros [31:26]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ok [0], payload_address [12:1], zeros [15:13]
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);

    localparam int NGRAN = HEAP_BYTES / GRANULE_BYTES;
    localparam int GW    = $clog2(NGRAN);
    localparam int SW    = $clog2(HEAP_BYTES) + 2;
    localparam int AW    = $clog2(HEAP_BYTES) + 1;
    localparam int GSH   = $clog2(GRANULE_BYTES);

    logic [SW-1:0] size_mem [NGRAN];
    logic [GW-1:0] link_mem [NGRAN];

    state_t        state_reg, state_next;
    logic [1:0]    fit_reg;
    logic [GW-1:0] head_reg, head_next;
    logic          hv_reg, hv_next;
    logic          cmd_reg, cmd_next;
    logic [SW-1:0] need_reg, need_next;
    logic [GW-1:0] g_reg, g_next;
    logic [GW-1:0] cur_reg, cur_next;
    logic [GW-1:0] best_reg, best_next;
    logic [SW-1:0] bsz_reg, bsz_next;
    logic          found_reg, found_next;
    logic [GW-1:0] pr_reg, pr_next;
    logic          hp_reg, hp_next;
    logic [SW-1:0] fsz_reg, fsz_next;
    logic [SW-1:0] gsz_reg, gsz_next;
    logic [GW-1:0] gl_reg, gl_next;
    logic [GW-1:0] nx_reg, nx_next;
    logic [GW-1:0] cnt_reg, cnt_next;
    logic          ok_reg, ok_next;
    logic [11:0]   pa_reg, pa_next;
    logic          mv_reg, mv_next;

    logic [GW-1:0] ra;
    logic [SW-1:0] rd_size;
    logic [GW-1:0] rd_link;
    logic          we_s, we_l;
    logic [GW-1:0] wa_s, wa_l;
    logic [SW-1:0] wd_s;
    logic [GW-1:0] wd_l;

    always_ff @(posedge clk)
    begin
        rd_size <= size_mem[ra];
        rd_link <= link_mem[ra];
        if (we_s)
        begin
            size_mem[wa_s] <= wd_s;
        end
        if (we_l)
        begin
            link_mem[wa_l] <= wd_l;
        end
    end

    logic          in_cmd;
    logic [12:0]   in_req;
    logic [11:0]   in_addr;
    logic [SW-1:0] req_need;
    logic [AW-1:0] za;
    logic [SW-1:0] alloc_w;
    logic [SW-1:0] start_b;

    assign in_cmd   = s_tdata[0];
    assign in_req   = s_tdata[13:1];
    assign in_addr  = s_tdata[25:14];
    assign req_need = SW'((({1'b0, in_req} + 14'(SIZE_ALIGN - 1)) & ~14'(SIZE_ALIGN - 1))
                      + 14'(USED_HEADER_BYTES));
    assign za       = AW'(in_addr) - AW'(USED_HEADER_BYTES);
    assign alloc_w  = need_reg + SW'(USED_HEADER_BYTES);
    assign start_b  = SW'(g_reg) << GSH;

    assign s_tready  = (state_reg == ST_IDLE) && !mv_reg;
    assign cfg_ready = (state_reg == ST_IDLE) || (state_reg == ST_CLEAR);
    assign m_tvalid  = mv_reg;
    assign m_tdata   = {3'b0, pa_reg, ok_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            fit_reg   <= FIT_FIRST;
            head_reg  <= '0;
            hv_reg    <= 1'b1;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            hv_reg    <= hv_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
            if (cfg_valid && cfg_ready)
            begin
                fit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        need_reg  <= need_next;
        g_reg     <= g_next;
        cur_reg   <= cur_next;
        best_reg  <= best_next;
        bsz_reg   <= bsz_next;
        found_reg <= found_next;
        pr_reg    <= pr_next;
        hp_reg    <= hp_next;
        fsz_reg   <= fsz_next;
        gsz_reg   <= gsz_next;
        gl_reg    <= gl_next;
        nx_reg    <= nx_next;
        ok_reg    <= ok_next;
        pa_reg    <= pa_next;
    end

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        hv_next    = hv_reg;
        cmd_next   = cmd_reg;
        need_next  = need_reg;
        g_next     = g_reg;
        cur_next   = cur_reg;
        best_next  = best_reg;
        bsz_next   = bsz_reg;
        found_next = found_reg;
        pr_next    = pr_reg;
        hp_next    = hp_reg;
        fsz_next   = fsz_reg;
        gsz_next   = gsz_reg;
        gl_next    = gl_reg;
        nx_next    = nx_reg;
        cnt_next   = cnt_reg;
        ok_next    = ok_reg;
        pa_next    = pa_reg;
        mv_next    = mv_reg && !m_tready;
        ra         = cur_reg;
        we_s       = 1'b0;
        we_l       = 1'b0;
        wa_s       = g_reg;
        wa_l       = g_reg;
        wd_s       = '0;
        wd_l       = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                we_s = 1'b1;
                we_l = 1'b1;
                wa_s = cnt_reg;
                wa_l = cnt_reg;
                wd_s = (cnt_reg == '0) ? SW'(HEAP_BYTES) : '0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == GW'(NGRAN - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cmd_next   = in_cmd;
                    need_next  = req_need;
                    ok_next    = 1'b0;
                    pa_next    = '0;
                    found_next = 1'b0;
                    cur_next   = head_reg;
                    cnt_next   = '0;
                    g_next     = GW'(za >> GSH);
                    if (in_cmd == CMD_ALLOC)
                    begin
                        if (in_req == '0 || !hv_reg)
                        begin
                            state_next = ST_REPLY;
                        end
                        else
                        begin
                            state_next = ST_FIT_RD;
                        end
                    end
                    else if (in_addr == '0)
                    begin
                        ok_next    = 1'b1;
                        state_next = ST_REPLY;
                    end
                    else if (AW'(in_addr) < AW'(USED_HEADER_BYTES)
                             || (za & AW'(GRANULE_BYTES - 1)) != '0
                             || za >= AW'(HEAP_BYTES))
                    begin
                        state_next = ST_REPLY;
                    end
                    else
                    begin
                        state_next = ST_INS_RD;
                    end
                end
            end
            ST_FIT_RD:
            begin
                ra = cur_reg;
                state_next = ST_FIT_CHK;
            end
            ST_FIT_CHK:
            begin
                cnt_next = cnt_reg + 1'b1;
                state_next = ST_FIT_RD;
                if (rd_size >= need_reg)
                begin
                    if (fit_reg == FIT_BEST)
                    begin
                        if (!found_reg || rd_size < bsz_reg)
                        begin
                            found_next = 1'b1;
                            best_next  = cur_reg;
                            bsz_next   = rd_size;
                        end
                    end
                    else if (fit_reg == FIT_WORST)
                    begin
                        if (!found_reg || rd_size > bsz_reg)
                        begin
                            found_next = 1'b1;
                            best_next  = cur_reg;
                            bsz_next   = rd_size;
                        end
                    end
                    else
                    begin
                        found_next = 1'b1;
                        best_next  = cur_reg;
                        state_next = ST_UNL_RD;
                    end
                end
                if (state_next == ST_FIT_RD)
                begin
                    if (rd_link == '0 || rd_link <= cur_reg || cnt_reg == GW'(NGRAN - 1))
                    begin
                        state_next = found_next ? ST_UNL_RD : ST_REPLY;
                    end
                    else
                    begin
                        cur_next = rd_link;
                    end
                end
                if (state_next == ST_UNL_RD)
                begin
                    g_next   = best_next;
                    cur_next = head_reg;
                    cnt_next = '0;
                end
            end
            ST_UNL_RD:
            begin
                ra = g_reg;
                state_next = ST_UNL_CHK;
            end
            ST_UNL_CHK:
            begin
                fsz_next = rd_size;
                gl_next  = rd_link;
                ok_next  = 1'b1;
                pa_next  = 12'(start_b + SW'(USED_HEADER_BYTES));
                if (head_reg == g_reg)
                begin
                    if (rd_link == '0)
                    begin
                        hv_next = 1'b0;
                    end
                    else
                    begin
                        head_next = rd_link;
                    end
                    state_next = ST_SPLIT;
                end
                else
                begin
                    state_next = ST_UNL_GRD;
                end
            end
            ST_UNL_GRD:
            begin
                ra = cur_reg;
                state_next = ST_UNL_GCHK;
            end
            ST_UNL_GCHK:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (rd_link == '0 || rd_link <= cur_reg || cnt_reg == GW'(NGRAN - 1))
                begin
                    state_next = ST_SPLIT;
                end
                else if (rd_link == g_reg)
                begin
                    we_l = 1'b1;
                    wa_l = cur_reg;
                    wd_l = gl_reg;
                    state_next = ST_SPLIT;
                end
                else
                begin
                    cur_next = rd_link;
                    state_next = ST_UNL_GRD;
                end
            end
            ST_SPLIT:
            begin
                if (fsz_reg >= alloc_w + SW'(FREE_HEADER_BYTES))
                begin
                    we_s = 1'b1;
                    wa_s = g_reg;
                    wd_s = alloc_w;
                    g_next   = GW'((start_b + alloc_w) >> GSH);
                    gsz_next = fsz_reg - alloc_w;
                    cur_next = head_reg;
                    cnt_next = '0;
                    state_next = ST_INS_RD;
                end
                else
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_INS_RD:
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    we_s = 1'b1;
                    wa_s = g_reg;
                    wd_s = gsz_reg;
                end
                hp_next = 1'b0;
                if (!hv_reg)
                begin
                    head_next = g_reg;
                    hv_next   = 1'b1;
                    we_l = 1'b1;
                    wd_l = '0;
                    state_next = ST_FREE_DONE;
                end
                else if (head_reg == g_reg)
                begin
                    state_next = ST_REPLY;
                end
                else if (head_reg > g_reg)
                begin
                    we_l = 1'b1;
                    wd_l = head_reg;
                    head_next = g_reg;
                    state_next = ST_FREE_DONE;
                end
                else
                begin
                    cur_next = head_reg;
                    cnt_next = '0;
                    state_next = ST_INS_PRD;
                end
            end
            ST_INS_PRD:
            begin
                ra = cur_reg;
                state_next = ST_INS_PCHK;
            end
            ST_INS_PCHK:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (rd_link == '0 || rd_link <= cur_reg || rd_link > g_reg
                    || cnt_reg == GW'(NGRAN - 1))
                begin
                    nx_next = (rd_link > cur_reg) ? rd_link : '0;
                    state_next = ST_INS_LINK;
                end
                else if (rd_link == g_reg)
                begin
                    state_next = ST_REPLY;
                end
                else
                begin
                    cur_next = rd_link;
                    state_next = ST_INS_PRD;
                end
            end
            ST_INS_LINK:
            begin
                we_l = 1'b1;
                wa_l = g_reg;
                wd_l = nx_reg;
                hp_next = 1'b1;
                pr_next = cur_reg;
                state_next = ST_INS_PLINK;
            end
            ST_INS_PLINK:
            begin
                we_l = 1'b1;
                wa_l = pr_reg;
                wd_l = g_reg;
                state_next = ST_FREE_DONE;
            end
            ST_FREE_DONE:
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    state_next = ST_REPLY;
                end
                else
                begin
                    ok_next = 1'b1;
                    state_next = ST_MRG_PRD;
                end
            end
            ST_MRG_PRD:
            begin
                ra = g_reg;
                state_next = ST_MRG_PCHK;
            end
            ST_MRG_PCHK:
            begin
                gsz_next = rd_size;
                gl_next  = rd_link;
                ra = pr_reg;
                state_next = ST_MRG_NRD;
            end
            ST_MRG_NRD:
            begin
                if (hp_reg && (SW'(pr_reg) << GSH) + rd_size == start_b)
                begin
                    we_s = 1'b1;
                    wa_s = pr_reg;
                    wd_s = rd_size + gsz_reg;
                    we_l = 1'b1;
                    wa_l = pr_reg;
                    wd_l = gl_reg;
                    gsz_next = rd_size + gsz_reg;
                    g_next = pr_reg;
                end
                state_next = ST_MRG_NCHK;
            end
            ST_MRG_NCHK:
            begin
                ra = gl_reg;
                state_next = ST_MRG_N2;
            end
            ST_MRG_N2:
            begin
                if (gl_reg != '0 && gl_reg > g_reg
                    && start_b + gsz_reg == SW'(gl_reg) << GSH)
                begin
                    we_s = 1'b1;
                    wa_s = g_reg;
                    wd_s = gsz_reg + rd_size;
                    we_l = 1'b1;
                    wa_l = g_reg;
                    wd_l = rd_link;
                end
                state_next = ST_MRG_N2CHK;
            end
            ST_MRG_N2CHK:
            begin
                state_next = ST_REPLY;
            end
            ST_REPLY:
            begin
                if (!mv_reg)
                begin
                    mv_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata));

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid);

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tdata[15:13] == 3'b0);

    a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> (state_reg == ST_IDLE || state_reg == ST_CLEAR));

endmodule

### bench/tb_free_list_heap_allocator.sv
module tb_free_list_heap_allocator
    import flha_pkg::*;
;

    localparam int NGRAN = HEAP_BYTES_DEF / GRANULE_BYTES_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [11:0] block_address;
        logic [12:0] request_size;
        logic        cmd;
    } request_t;

    typedef struct packed {
        logic [11:0] payload_address;
        logic        ok;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;

    free_list_heap_allocator i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    // Predictor state of the heap.
    logic [1:0]  mdl_fit;
    logic [12:0] mdl_size [NGRAN];
    logic [9:0]  mdl_next [NGRAN];
    logic [9:0]  mdl_head;
    logic        mdl_head_valid;

    request_t pending_requests[$];
    reply_t   expected_replies[$];
    logic [11:0] live_blocks[$];

    int  errors = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_alloc_ok = 0;
    int  n_merged = 0;
    int  idle_cycles = 0;
    int  hold_off = 0;
    int  recv_gap = 0;
    logic s_tready_q = 1'b0;
    logic m_acc_q = 1'b0;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic bit heap_find(input int need, output int pick);
        bit found;
        int bsize;
        int cur;
        int nxt;
        found = 0;
        bsize = 0;
        pick = 0;
        cur = mdl_head;
        if (!mdl_head_valid)
            return 0;
        for (int n = 0; n < NGRAN; n++)
        begin
            if (mdl_size[cur] >= need)
            begin
                if (mdl_fit == FIT_BEST)
                begin
                    if (!found || mdl_size[cur] < bsize)
                    begin
                        found = 1;
                        pick = cur;
                        bsize = mdl_size[cur];
                    end
                end
                else if (mdl_fit == FIT_WORST)
                begin
                    if (!found || mdl_size[cur] > bsize)
                    begin
                        found = 1;
                        pick = cur;
                        bsize = mdl_size[cur];
                    end
                end
                else
                begin
                    found = 1;
                    pick = cur;
                    break;
                end
            end
            nxt = mdl_next[cur];
            if (nxt == 0 || nxt <= cur)
                break;
            cur = nxt;
        end
        return found;
    endfunction

    function automatic void heap_unlink(input int g);
        int p;
        int nxt;
        p = mdl_head;
        if (!mdl_head_valid)
            return;
        if (p == g)
        begin
            if (mdl_next[g] == 0)
                mdl_head_valid = 1'b0;
            else
                mdl_head = mdl_next[g];
            return;
        end
        for (int n = 0; n < NGRAN; n++)
        begin
            nxt = mdl_next[p];
            if (nxt == 0 || nxt <= p)
                return;
            if (nxt == g)
            begin
                mdl_next[p] = mdl_next[g];
                return;
            end
            p = nxt;
        end
    endfunction

    function automatic bit heap_insert(input int g, output bit has_pred, output int pred);
        int p;
        int nxt;
        p = mdl_head;
        has_pred = 0;
        pred = 0;
        if (!mdl_head_valid)
        begin
            mdl_head = 10'(g);
            mdl_next[g] = '0;
            mdl_head_valid = 1'b1;
            return 1;
        end
        if (p == g)
            return 0;
        if (p > g)
        begin
            mdl_next[g] = 10'(p);
            mdl_head = 10'(g);
            return 1;
        end
        for (int n = 0; n < NGRAN; n++)
        begin
            nxt = mdl_next[p];
            if (nxt == 0 || nxt <= p || nxt > g)
                break;
            if (nxt == g)
                return 0;
            p = nxt;
        end
        nxt = mdl_next[p];
        mdl_next[g] = 10'((nxt > p) ? nxt : 0);
        mdl_next[p] = 10'(g);
        has_pred = 1;
        pred = p;
        return 1;
    endfunction

    function automatic reply_t heap_execute(input request_t req);
        reply_t rsp;
        int need;
        int g;
        int fsz;
        int alloc;
        int r;
        int pr;
        int nx;
        int za;
        bit hp;
        rsp = '0;
        if (req.cmd == CMD_ALLOC)
        begin
            if (req.request_size == 0)
                return rsp;
            need = ((int'(req.request_size) + SIZE_ALIGN - 1) & ~(SIZE_ALIGN - 1))
                   + USED_HEADER_BYTES_DEF;
            if (!heap_find(need, g))
                return rsp;
            fsz = mdl_size[g];
            heap_unlink(g);
            alloc = need + USED_HEADER_BYTES_DEF;
            if (fsz >= alloc + FREE_HEADER_BYTES_DEF)
            begin
                r = ((g * GRANULE_BYTES_DEF + alloc) / GRANULE_BYTES_DEF) % NGRAN;
                mdl_size[g] = 13'(alloc);
                mdl_size[r] = 13'(fsz - alloc);
                void'(heap_insert(r, hp, pr));
            end
            rsp.ok = 1'b1;
            rsp.payload_address = 12'(g * GRANULE_BYTES_DEF + USED_HEADER_BYTES_DEF);
            n_alloc_ok++;
            live_blocks.push_back(rsp.payload_address);
            return rsp;
        end
        if (req.block_address == 0)
        begin
            rsp.ok = 1'b1;
            return rsp;
        end
        if (req.block_address < USED_HEADER_BYTES_DEF)
            return rsp;
        za = int'(req.block_address) - USED_HEADER_BYTES_DEF;
        if (za % GRANULE_BYTES_DEF != 0 || za >= HEAP_BYTES_DEF)
            return rsp;
        g = za / GRANULE_BYTES_DEF;
        if (!heap_insert(g, hp, pr))
            return rsp;
        if (hp && pr * GRANULE_BYTES_DEF + mdl_size[pr] == g * GRANULE_BYTES_DEF)
        begin
            mdl_size[pr] = mdl_size[pr] + mdl_size[g];
            mdl_next[pr] = mdl_next[g];
            g = pr;
            n_merged++;
        end
        nx = mdl_next[g];
        if (nx != 0 && nx > g && g * GRANULE_BYTES_DEF + mdl_size[g] == nx * GRANULE_BYTES_DEF)
        begin
            mdl_size[g] = mdl_size[g] + mdl_size[nx];
            mdl_next[g] = mdl_next[nx];
            n_merged++;
        end
        rsp.ok = 1'b1;
        return rsp;
    endfunction

    function automatic request_t make_alloc(input int sz);
        request_t req;
        req = '0;
        req.cmd = CMD_ALLOC;
        req.request_size = 13'(sz);
        req.block_address = 12'($urandom);
        return req;
    endfunction

    function automatic request_t make_free(input int addr);
        request_t req;
        req = '0;
        req.cmd = CMD_FREE;
        req.request_size = 13'($urandom);
        req.block_address = 12'(addr);
        return req;
    endfunction

    // Sender: one request from the pending queue at a time, with random gaps.
    int send_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready_q)
            begin
                send_gap = $urandom_range(0, 3);
                if ($urandom_range(0, 3) == 0)
                    send_gap = 0;
            end
            if (s_tvalid && !s_tready_q)
            begin
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                s_tdata <= {6'b0, pending_requests.pop_front()};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Request acceptance seen at the rising edge feeds the predictor.
    always @(posedge clk)
    begin
        s_tready_q <= 1'b0;
        if (rst_n && s_tvalid && s_tready)
        begin
            s_tready_q <= 1'b1;
            expected_replies.push_back(heap_execute(request_t'(s_tdata[25:0])));
            n_sent++;
        end
    end

    // Receiver with a random wait per reply and a long hold-off when the stimulus sets one.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (m_acc_q)
                recv_gap = $urandom_range(0, 3);
            if (hold_off > 0)
            begin
                hold_off--;
                m_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        reply_t got;
        reply_t exp_rsp;
        m_acc_q <= 1'b0;
        if (rst_n && m_tvalid && m_tready)
        begin
            m_acc_q <= 1'b1;
            got = reply_t'(m_tdata[12:0]);
            if (m_tdata[15:13] != 3'b0)
            begin
                $display("%0t: padding bits set, expected 0 actual %h", $time, m_tdata[15:13]);
                errors++;
            end
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected reply, expected none actual ok=%0d addr=%0d",
                         $time, got.ok, got.payload_address);
                errors++;
            end
            else
            begin
                exp_rsp = expected_replies.pop_front();
                if (got.ok !== exp_rsp.ok)
                begin
                    $display("%0t: ok mismatch, expected %0d actual %0d",
                             $time, exp_rsp.ok, got.ok);
                    errors++;
                end
                if (got.payload_address !== exp_rsp.payload_address)
                begin
                    $display("%0t: payload_address mismatch, expected %0d actual %0d",
                             $time, exp_rsp.payload_address, got.payload_address);
                    errors++;
                end
                n_checked++;
            end
        end
    end

    // Watchdog: cycles with no handshake of any kind.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_requests.size() > 0 || s_tvalid || expected_replies.size() > 0)
            @(posedge clk);
        repeat (2 * NGRAN + 40) @(posedge clk);
    endtask

    task automatic write_fit(input logic [1:0] mode);
        @(negedge clk);
        cfg_data <= mode;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mdl_fit = mode;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_phase(input int count);
        int idx;
        int sz;
        for (int i = 0; i < count; i++)
        begin
            while (pending_requests.size() > 4)
                @(posedge clk);
            if (live_blocks.size() > 0 && $urandom_range(0, 99) < 45)
            begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                pending_requests.push_back(make_free(live_blocks[idx]));
                live_blocks.delete(idx);
            end
            else if ($urandom_range(0, 99) < 10)
                pending_requests.push_back(make_free($urandom_range(0, 4095)));
            else
            begin
                case ($urandom_range(0, 9))
                    0: sz = $urandom_range(0, 8191);
                    1: sz = $urandom_range(400, 2000);
                    default: sz = $urandom_range(1, 200);
                endcase
                pending_requests.push_back(make_alloc(sz));
            end
            @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = FIT_FIRST;
        for (int g = 0; g < NGRAN; g++)
        begin
            mdl_size[g] = '0;
            mdl_next[g] = '0;
        end
        mdl_size[0] = 13'(HEAP_BYTES_DEF);
        mdl_head = '0;
        mdl_head_valid = 1'b1;
        mdl_fit = FIT_FIRST;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: size extremes, no fit, null, bad and double frees.
        pending_requests.push_back(make_alloc(0));
        pending_requests.push_back(make_alloc(4096));
        pending_requests.push_back(make_alloc(8191));
        pending_requests.push_back(make_alloc(1));
        pending_requests.push_back(make_alloc(100));
        pending_requests.push_back(make_alloc(7));
        pending_requests.push_back(make_free(0));
        pending_requests.push_back(make_free(4));
        pending_requests.push_back(make_free(13));
        pending_requests.push_back(make_free(4095));
        pending_requests.push_back(make_free(40));
        pending_requests.push_back(make_free(40));
        pending_requests.push_back(make_free(8));
        pending_requests.push_back(make_free(24));
        pending_requests.push_back(make_alloc(4040));
        pending_requests.push_back(make_alloc(3000));
        pending_requests.push_back(make_free(4088));
        pending_requests.push_back(make_free(2048));
        wait_drained();
        live_blocks.delete();

        // Long receiver hold-off so the block backs up its input.
        hold_off = 300;
        for (int i = 0; i < 8; i++)
            pending_requests.push_back(make_alloc($urandom_range(1, 64)));
        wait_drained();

        for (int phase = 0; phase < 8; phase++)
        begin
            write_fit(phase == 6 ? 2'd3 : 2'(phase % 3));
            queue_phase(115);
            wait_drained();
        end

        $display("Covered %0d requests, %0d replies checked, %0d allocations granted,",
                 n_sent, n_checked, n_alloc_ok);
        $display("%0d coalescing merges, across all fit modes including the unused one.",
                 n_merged);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
